// ===== src/aesbcm_pkg.sv =====
// ----------------------------------------------------------------------------
// AES block cipher package
// Shared types, register indexes, mode codes and the S-box tables.
// ----------------------------------------------------------------------------
package aesbcm_pkg;

  localparam int MaxRoundsDefault = 14;

  typedef struct packed {
    logic        action;
    logic        restart;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_item_t;

  localparam logic [2:0] REG_KEY0  = 3'd0;
  localparam logic [2:0] REG_KEY1  = 3'd1;
  localparam logic [2:0] REG_KEY2  = 3'd2;
  localparam logic [2:0] REG_KEY3  = 3'd3;
  localparam logic [2:0] REG_KSIZE = 3'd4;
  localparam logic [2:0] REG_MODE  = 3'd5;
  localparam logic [2:0] REG_IVH   = 3'd6;
  localparam logic [2:0] REG_IVL   = 3'd7;

  localparam logic [2:0] MODE_ECB = 3'd0;
  localparam logic [2:0] MODE_CBC = 3'd1;
  localparam logic [2:0] MODE_CFB = 3'd2;
  localparam logic [2:0] MODE_OFB = 3'd3;
  localparam logic [2:0] MODE_CTR = 3'd4;

  localparam logic [7:0] FWD_BOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_BOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {FWD_BOX[w[31:24]], FWD_BOX[w[23:16]], FWD_BOX[w[15:8]], FWD_BOX[w[7:0]]};
  endfunction

endpackage

// ===== src/aes_block_cipher_with_modes.sv =====
// ----------------------------------------------------------------------------
// AES block cipher with chaining modes
// AES-128/192/256 in ECB, CBC, CFB, OFB and CTR with an iterative round core.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake       | Payload
//  in_     | input     | valid / ready   | in_item_t (action, restart, block)
//  out_    | output    | valid / ready   | out_item_t (result block)
//  cfg_    | input     | write enable    | index 0..7, 64-bit data
//
//  An accepted item goes through load, Nr + 1 round-key rows in the shared
//  round core and chaining, then waits at out_ until it is taken; only then
//  is the next transaction accepted.
//  The first item after reset or a key or key-size write adds a key expansion
//  of 4 * (Nr + 1) words, one word per cycle.
//  Reset is synchronous, active low; round-key memory is not cleared.
//  in_ready is low from acceptance until the result is taken at out_.
// ----------------------------------------------------------------------------
module aes_block_cipher_with_modes #(
  parameter int MAX_ROUNDS = aesbcm_pkg::MaxRoundsDefault
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  aesbcm_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output aesbcm_pkg::out_item_t out_data,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [63:0]           cfg_wdata
);
  import aesbcm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_KEYX = 3'd1;
  localparam logic [2:0] S_GO   = 3'd2;
  localparam logic [2:0] S_RUN  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  // clamp key size to what MAX_ROUNDS allows; code 3 means 256-bit
  localparam logic [1:0] MaxKs = (MAX_ROUNDS >= 14) ? 2'd2 : (MAX_ROUNDS >= 12) ? 2'd1 : 2'd0;

  logic [63:0] key_r [4];
  logic [1:0]  ksize_r;
  logic [2:0]  mode_r;
  logic [63:0] ivh_r, ivl_r;
  logic        keys_ready_r;
  logic [127:0] chain_r;
  logic [7:0]  ctr_r;
  logic [2:0]  st_r;
  in_item_t    item_r;
  out_item_t   res_r;

  logic [1:0] eff_ks;
  always_comb begin
    eff_ks = (ksize_r == 2'd3) ? 2'd2 : ksize_r;
    if (eff_ks > MaxKs) eff_ks = MaxKs;
  end
  logic [3:0] nrounds;
  assign nrounds = 4'd10 + {1'b0, eff_ks, 1'b0};

  logic kx_start, kx_busy, core_start, core_done;
  logic [127:0] core_in, core_out;
  logic core_inv;

  aesbcm_core #(.MAX_ROUNDS(MAX_ROUNDS)) u_core (
    .clk, .rst_n,
    .start(core_start), .inverse(core_inv), .nrounds(nrounds),
    .din(core_in), .done(core_done), .dout(core_out),
    .kx_start(kx_start), .ksize(eff_ks),
    .key({key_r[0], key_r[1], key_r[2], key_r[3]}), .kx_busy(kx_busy)
  );

  logic [127:0] x, ctr_blk;
  logic dec;
  assign x   = {item_r.block_high, item_r.block_low};
  assign dec = item_r.action;
  assign ctr_blk = {chain_r[127:8], chain_r[7:0] + ctr_r};

  // Select what the forward or inverse cipher works on
  always_comb begin
    core_inv = 1'b0;
    core_in  = x;
    case (mode_r) inside
      MODE_CBC: begin
        core_inv = dec;
        core_in  = dec ? x : (x ^ chain_r);
      end
      MODE_CFB, MODE_OFB: core_in = chain_r;
      MODE_CTR:           core_in = ctr_blk;
      default:            core_inv = dec;
    endcase
  end

  assign kx_start   = (st_r == S_IDLE) && in_valid && !keys_ready_r;
  assign core_start = (st_r == S_GO);
  assign in_ready   = (st_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      keys_ready_r <= 1'b0;
      chain_r      <= '0;
      ctr_r        <= '0;
      key_r        <= '{default: '0};
      ksize_r      <= '0;
      mode_r       <= MODE_ECB;
      ivh_r        <= '0;
      ivl_r        <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KEY0:  begin key_r[0] <= cfg_wdata; keys_ready_r <= 1'b0; end
          REG_KEY1:  begin key_r[1] <= cfg_wdata; keys_ready_r <= 1'b0; end
          REG_KEY2:  begin key_r[2] <= cfg_wdata; keys_ready_r <= 1'b0; end
          REG_KEY3:  begin key_r[3] <= cfg_wdata; keys_ready_r <= 1'b0; end
          REG_KSIZE: begin ksize_r <= cfg_wdata[1:0]; keys_ready_r <= 1'b0; end
          REG_MODE:  mode_r <= cfg_wdata[2:0];
          REG_IVH:   ivh_r  <= cfg_wdata;
          REG_IVL:   ivl_r  <= cfg_wdata;
          default:   ;
        endcase
      end
      unique case (st_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r <= in_data;
            // restart reloads the chain and clears the counter up front
            if (in_data.restart) begin
              chain_r <= {ivh_r, ivl_r};
              ctr_r   <= '0;
            end
            st_r <= keys_ready_r ? S_GO : S_KEYX;
          end
        end
        S_KEYX: begin
          // hold until the schedule is written
          if (!kx_busy) begin
            keys_ready_r <= 1'b1;
            st_r <= S_GO;
          end
        end
        S_GO: st_r <= S_RUN;
        S_RUN: begin
          if (core_done) begin
            ctr_r <= ctr_r + 8'd1;
            case (mode_r)
              MODE_CBC: begin
                res_r   <= dec ? (core_out ^ chain_r) : core_out;
                chain_r <= dec ? x : core_out;
              end
              MODE_CFB: begin
                res_r   <= core_out ^ x;
                chain_r <= dec ? x : (core_out ^ x);
              end
              MODE_OFB: begin
                res_r   <= core_out ^ x;
                chain_r <= core_out;
              end
              MODE_CTR: res_r <= core_out ^ x;
              default:  res_r <= core_out;
            endcase
            st_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = (st_r == S_OUT);
  assign out_data  = res_r;
endmodule

// ===== src/aesbcm_core.sv =====
// ----------------------------------------------------------------------------
// AES round core
// One round per cycle on a 128-bit state; round keys are expanded one word a
// cycle, written to a memory as rows of four words and read as a row when used.
// ----------------------------------------------------------------------------
module aesbcm_core #(
  parameter int MAX_ROUNDS = aesbcm_pkg::MaxRoundsDefault
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic         inverse,
  input  logic [3:0]   nrounds,
  input  logic [127:0] din,
  output logic         done,
  output logic [127:0] dout,
  // key expansion
  input  logic         kx_start,
  input  logic [1:0]   ksize,
  input  logic [255:0] key,
  output logic         kx_busy
);
  import aesbcm_pkg::*;

  localparam int RowCnt = MAX_ROUNDS + 1;
  localparam int RowW   = $clog2(RowCnt);
  localparam int WordCnt = 4 * RowCnt;
  localparam int WordW  = $clog2(WordCnt + 1);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_RUN  = 2'd1;
  localparam logic [1:0] C_FIN  = 2'd2;

  // round key memory, one row of four words per round key
  logic [127:0] rk_mem [RowCnt];
  logic [127:0] rk_q;
  logic [RowW-1:0] rd_row;

  // key expansion: sliding window of the last eight words
  logic [31:0]  win_r [8];
  logic [WordW-1:0] kw_r;       // next word index
  logic [WordW-1:0] ktot_r;
  logic [3:0]   nk_r, kmod_r;
  logic [7:0]   rcon_r;
  logic         kx_busy_r;
  logic [95:0]  row_acc_r;

  logic [31:0] prev_w, tmp_w, new_w;
  always_comb begin
    prev_w = win_r[0];
    tmp_w  = prev_w;
    if (kmod_r == 4'd0) begin
      tmp_w = sub_word({prev_w[23:0], prev_w[31:24]}) ^ {rcon_r, 24'h0};
    end else if (nk_r == 4'd8 && kmod_r == 4'd4) begin
      tmp_w = sub_word(prev_w);
    end
    new_w = win_r[3'(nk_r - 4'd1)] ^ tmp_w;
  end

  assign kx_busy = kx_busy_r;

  logic [3:0] knk;
  always_comb begin
    unique case (ksize)
      2'd0:    knk = 4'd4;
      2'd1:    knk = 4'd6;
      default: knk = 4'd8;
    endcase
  end

  logic [31:0] load_w [8];
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      load_w[i] = key[255 - 32*i -: 32];
    end
  end

  // word sequence: first nk words come from the key, then the recurrence
  logic [31:0] cur_w;
  assign cur_w = (kw_r < WordW'(nk_r)) ? load_w[kw_r[2:0]] : new_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kx_busy_r <= 1'b0;
    end else if (kx_start) begin
      kx_busy_r <= 1'b1;
      kw_r      <= '0;
      nk_r      <= knk;
      kmod_r    <= 4'd0;
      rcon_r    <= 8'h01;
      ktot_r    <= WordW'(4 * (6 + 32'(knk) + 1));
    end else if (kx_busy_r) begin
      for (int i = 7; i > 0; i--) begin
        win_r[i] <= win_r[i-1];
      end
      win_r[0] <= cur_w;
      if (kw_r >= WordW'(nk_r)) begin
        kmod_r <= (kmod_r == nk_r - 4'd1) ? 4'd0 : kmod_r + 4'd1;
        if (kmod_r == 4'd0) begin
          rcon_r <= xtime(rcon_r);
        end
      end
      if (kw_r[1:0] == 2'd3) begin
        rk_mem[kw_r[WordW-1:2]] <= {row_acc_r, cur_w};
      end else begin
        row_acc_r <= {row_acc_r[63:0], cur_w};
      end
      kw_r <= kw_r + 1'b1;
      if (kw_r == ktot_r - 1'b1 || kw_r == WordW'(WordCnt - 1)) begin
        kx_busy_r <= 1'b0;
      end
    end
  end

  // ---------------- rounds ----------------
  logic [1:0]   cst_r;
  logic [3:0]   rnd_r;      // rounds completed (keys used so far)
  logic [127:0] st_r;
  logic         inv_r;
  logic [3:0]   nr_r;

  always_ff @(posedge clk) begin
    rk_q <= rk_mem[rd_row];
  end

  function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] m);
    logic [7:0] a2, a4, a8, p;
    a2 = xtime(a); a4 = xtime(a2); a8 = xtime(a4);
    p = 8'h00;
    if (m[0]) p = p ^ a;
    if (m[1]) p = p ^ a2;
    if (m[2]) p = p ^ a4;
    if (m[3]) p = p ^ a8;
    gm = p;
  endfunction

  localparam int Perm [16] = '{0,5,10,15,4,9,14,3,8,13,2,7,12,1,6,11};

  logic [7:0] s_in [16], s_ss [16], ak [16];
  logic first_rnd, last_rnd;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s_in[i] = st_r[127 - 8*i -: 8];
      ak[i]   = rk_q[127 - 8*i -: 8];
    end
    for (int i = 0; i < 16; i++) begin
      s_ss[i] = 8'h00;
    end
    for (int i = 0; i < 16; i++) begin
      if (inv_r) s_ss[Perm[i]] = INV_BOX[s_in[i]];
      else       s_ss[i] = FWD_BOX[s_in[Perm[i]]];
    end
  end

  // Forward round: st = mix(sub_shift(st)) ^ rk (mix skipped on the last).
  // Inverse round: st = sub_shift_inv(mix_inv(st ^ rk)) (mix skipped on first).
  logic [7:0] fa [16], fm [16], ia [16], im [16], is [16];
  logic [127:0] fwd_next, inv_next, inv_xk;
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      fa[i] = s_ss[i];
    end
    for (int c = 0; c < 16; c += 4) begin
      for (int r = 0; r < 4; r++) begin
        fm[c+r] = gm(fa[c+r], 4'h2) ^ gm(fa[c+((r+1)&3)], 4'h3)
                ^ fa[c+((r+2)&3)] ^ fa[c+((r+3)&3)];
      end
    end
    for (int i = 0; i < 16; i++) begin
      fwd_next[127 - 8*i -: 8] = (last_rnd ? fa[i] : fm[i]) ^ ak[i];
      ia[i] = s_in[i] ^ ak[i];
    end
    for (int c = 0; c < 16; c += 4) begin
      for (int r = 0; r < 4; r++) begin
        im[c+r] = gm(ia[c+r], 4'hE) ^ gm(ia[c+((r+1)&3)], 4'hB)
                ^ gm(ia[c+((r+2)&3)], 4'hD) ^ gm(ia[c+((r+3)&3)], 4'h9);
      end
    end
    for (int i = 0; i < 16; i++) begin
      is[i] = 8'h00;
    end
    for (int i = 0; i < 16; i++) begin
      is[Perm[i]] = INV_BOX[first_rnd ? ia[i] : im[i]];
    end
    for (int i = 0; i < 16; i++) begin
      inv_next[127 - 8*i -: 8] = is[i];
    end
    inv_xk = {ia[0],ia[1],ia[2],ia[3],ia[4],ia[5],ia[6],ia[7],
              ia[8],ia[9],ia[10],ia[11],ia[12],ia[13],ia[14],ia[15]};
  end

  // rnd_r counts round-key rows applied; row for next cycle is prefetched
  assign first_rnd = (rnd_r == 4'd0);
  assign last_rnd  = (rnd_r == nr_r);

  always_comb begin
    if (cst_r == C_IDLE) begin
      rd_row = start ? (inverse ? RowW'(nrounds) : '0) : '0;
    end else begin
      rd_row = inv_r ? RowW'(nr_r - rnd_r - 4'd1) : RowW'(rnd_r + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cst_r <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (cst_r)
        C_IDLE: begin
          if (start) begin
            cst_r <= C_RUN;
            st_r  <= din;
            inv_r <= inverse;
            nr_r  <= nrounds;
            rnd_r <= 4'd0;
          end
        end
        C_RUN: begin
          if (!inv_r) begin
            // first cycle: add round key 0 only
            st_r <= first_rnd ? (st_r ^ rk_q) : fwd_next;
          end else begin
            st_r <= (rnd_r == nr_r) ? inv_xk : inv_next;
          end
          rnd_r <= rnd_r + 4'd1;
          if (rnd_r == nr_r) begin
            cst_r <= C_FIN;
            done  <= 1'b1;
          end
        end
        C_FIN:   cst_r <= C_IDLE;
        default: cst_r <= C_IDLE;
      endcase
    end
  end

  assign dout = st_r;
endmodule

// ===== src/aesbcm_checker.sv =====
// ----------------------------------------------------------------------------
// AES block cipher port checker
// Watches the handshakes of the top level and flags ordering slips.
// ----------------------------------------------------------------------------
module aesbcm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [127:0] out_payload
);
  // no acceptance while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  // no result straight after an accepted transaction
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_payload))
    else $error("result dropped or changed");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result after reset");
endmodule

bind aes_block_cipher_with_modes aesbcm_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_payload(out_data)
);
